// ----- rtl/scwf_pkg.sv -----
// shared types, constants and the fixed channel frequency table
// for the channel word frame block; no dependencies
package scwf_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_REF_DIVIDER = 2'd0;
  localparam logic [1:0] CFG_REF_CLOCK   = 2'd1;
  localparam int CFG_IDX_W = 2;

  // field widths
  localparam int FREQ_W    = 13;
  localparam int REF_DIV_W = 20;
  localparam int REF_CLK_W = 8;
  localparam int PROD_W    = FREQ_W + REF_DIV_W;
  localparam int VALUE_W   = 20;
  localparam int ADDR_W    = 4;
  localparam int FRAME_BITS = 25;
  localparam int IDX_W     = 7;

  // reset values of the configuration registers
  localparam logic [REF_DIV_W-1:0] REF_DIVIDER_RST = 20'd400;
  localparam logic [REF_CLK_W-1:0] REF_CLOCK_RST   = 8'd8;

  // divider pipeline shape: quotient bits resolved per stage
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (PROD_W + DIV_STEPS - 1) / DIV_STEPS;

  // table size
  localparam int FIXED_ENTRIES = 72;
  localparam int TABLE_ENTRIES_DEF = 72;

  // synthesizer register addresses
  localparam logic [ADDR_W-1:0] ADDR_REF  = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_ZERO = 4'hF;
  localparam logic [ADDR_W-1:0] ADDR_WORD = 4'h1;

  // frame order within one request
  localparam logic [1:0] FRAME_REF  = 2'd0;
  localparam logic [1:0] FRAME_ZERO = 2'd1;
  localparam logic [1:0] FRAME_WORD = 2'd2;

  // word carried between divider stages
  typedef struct packed {
    logic                 valid;
    logic                 bad;
    logic [PROD_W-1:0]    num;  // dividend bits shift out on top, quotient in below
    logic [REF_CLK_W-1:0] rem;
    logic [REF_CLK_W-1:0] den;
  } div_word_t;

  localparam logic [FREQ_W-1:0] FREQ_TABLE [FIXED_ENTRIES] = '{
    13'd5865, 13'd5845, 13'd5825, 13'd5805, 13'd5785, 13'd5765, 13'd5745, 13'd5725,
    13'd5733, 13'd5752, 13'd5771, 13'd5790, 13'd5809, 13'd5828, 13'd5847, 13'd5866,
    13'd5705, 13'd5685, 13'd5665, 13'd5645, 13'd5885, 13'd5905, 13'd5925, 13'd5945,
    13'd5740, 13'd5760, 13'd5780, 13'd5800, 13'd5820, 13'd5840, 13'd5860, 13'd5880,
    13'd5658, 13'd5695, 13'd5732, 13'd5769, 13'd5806, 13'd5843, 13'd5880, 13'd5917,
    13'd5362, 13'd5399, 13'd5436, 13'd5473, 13'd5510, 13'd5547, 13'd5584, 13'd5621,
    13'd5325, 13'd5348, 13'd5366, 13'd5384, 13'd5402, 13'd5420, 13'd5438, 13'd5456,
    13'd5474, 13'd5492, 13'd5510, 13'd5528, 13'd5546, 13'd5564, 13'd5582, 13'd5600,
    13'd5653, 13'd5693, 13'd5733, 13'd5773, 13'd5813, 13'd5853, 13'd5893, 13'd5933
  };

  // frequency in MHz, zero past the fixed entries
  function automatic logic [FREQ_W-1:0] freq_lookup(input logic [IDX_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    f = '0;
    if (idx < IDX_W'(FIXED_ENTRIES)) begin
      f = FREQ_TABLE[idx];
    end
    return f;
  endfunction

endpackage

// ----- rtl/synth_channel_word_frames_unit.sv -----
// top level: config registers, lookup and product front, divider pipeline, frame output
// depends on scwf_pkg, scwf_front, scwf_div_stage, scwf_serializer
//
// Takes a band group and channel word, looks up the channel frequency f, forms
// x = (f * ref_divider / ref_clock_mhz) / 2 and sends three write frames: register 0
// with the reference divider, register 15 with zero, register 1 with the synthesizer
// word. A group or channel out of range gives a single all-zero frame with tuser set.
// Input words pass the lookup register, the multiply register, 11 divider stages of 3
// quotient bits each and the output register. The output register emits one frame per
// cycle while m_tready is high; a request takes 3 frames of output (1 when rejected),
// and the pipeline accepts a new word each time the output register frees.
module synth_channel_word_frames_unit import scwf_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [3:0] band_group, [7:4] channel
  // frame stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // [24:0] frame, [31:25] zero
  output logic                 m_tlast,   // last_frame
  output logic [0:0]           m_tuser,   // [0] bad_select
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REF_DIV_W-1:0] cfg_data
);

  logic                 advance;
  logic [REF_DIV_W-1:0] ref_divider;
  logic [REF_CLK_W-1:0] ref_clock_mhz;
  div_word_t            pipe [DIV_STAGES+1];

  assign cfg_ready = 1'b1;
  assign s_tready  = advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_divider   <= REF_DIVIDER_RST;
      ref_clock_mhz <= REF_CLOCK_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_REF_DIVIDER) begin
        ref_divider <= cfg_data;
      end else if (cfg_index == CFG_REF_CLOCK) begin
        ref_clock_mhz <= cfg_data[REF_CLK_W-1:0];
      end
    end
  end

  scwf_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (s_tvalid),
    .band_group    (s_tdata[3:0]),
    .channel       (s_tdata[7:4]),
    .ref_divider   (ref_divider),
    .ref_clock_mhz (ref_clock_mhz),
    .out           (pipe[0])
  );

  // divider pipeline
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    scwf_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .in      (pipe[g]),
      .out     (pipe[g+1])
    );
  end

  scwf_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .in          (pipe[DIV_STAGES]),
    .ref_divider (ref_divider),
    .advance     (advance),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser[0])
  );

endmodule

// ----- rtl/scwf_front.sv -----
// request check, table lookup and frequency times divider product
// depends on scwf_pkg
module scwf_front import scwf_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic [3:0]           band_group,
  input  logic [3:0]           channel,
  input  logic [REF_DIV_W-1:0] ref_divider,
  input  logic [REF_CLK_W-1:0] ref_clock_mhz,
  output div_word_t            out
);

  localparam logic [IDX_W:0] ENTRY_LIMIT = (IDX_W+1)'(TABLE_ENTRIES);

  logic [3:0]        grp_m1;
  logic [3:0]        chn_m1;
  logic [IDX_W-1:0]  idx;
  logic              bad_sel;

  // lookup stage registers
  logic              look_valid;
  logic              look_bad;
  logic [FREQ_W-1:0] look_freq;

  // range check and table index
  always_comb begin
    grp_m1  = band_group - 4'd1;
    chn_m1  = channel - 4'd1;
    idx     = {grp_m1, chn_m1[2:0]};
    bad_sel = (band_group < 4'd1) || (band_group > 4'd9) ||
              (channel < 4'd1) || (channel > 4'd8) ||
              ({1'b0, idx} >= ENTRY_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      look_valid <= 1'b0;
    end else if (advance) begin
      look_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      look_bad  <= bad_sel;
      look_freq <= freq_lookup(idx);
    end
  end

  // product stage, zero divisor taken as one
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (advance) begin
      out.valid <= look_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out.bad <= look_bad;
      out.num <= PROD_W'(look_freq) * PROD_W'(ref_divider);
      out.rem <= '0;
      out.den <= (ref_clock_mhz == '0) ? REF_CLK_W'(1) : ref_clock_mhz;
    end
  end

endmodule

// ----- rtl/scwf_div_stage.sv -----
// one stage of the restoring divider, DIV_STEPS quotient bits per stage
// depends on scwf_pkg
module scwf_div_stage import scwf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  div_word_t in,
  output div_word_t out
);

  logic [PROD_W-1:0]    num;
  logic [REF_CLK_W:0]   part;
  logic [REF_CLK_W-1:0] rem;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    num = in.num;
    rem = in.rem;
    part = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      part = {rem, num[PROD_W-1]};
      num  = {num[PROD_W-2:0], 1'b0};
      if (part >= {1'b0, in.den}) begin
        part   = part - {1'b0, in.den};
        num[0] = 1'b1;
      end
      rem = part[REF_CLK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (advance) begin
      out.valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out.bad <= in.bad;
      out.num <= num;
      out.rem <= rem;
      out.den <= in.den;
    end
  end

endmodule

// ----- rtl/scwf_serializer.sv -----
// output register that sends the three write frames of one request, or one all-zero frame when rejected
// depends on scwf_pkg
module scwf_serializer import scwf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  div_word_t            in,
  input  logic [REF_DIV_W-1:0] ref_divider,
  output logic                 advance,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);

  logic               hold_valid;
  logic               hold_bad;
  logic [VALUE_W-1:0] hold_word;
  logic [1:0]         cnt;

  logic               last;
  logic [ADDR_W-1:0]  addr;
  logic [VALUE_W-1:0] value;
  logic [FRAME_BITS-1:0] frame;

  assign last    = hold_bad || (cnt == FRAME_WORD);
  assign advance = !hold_valid || (m_tready && last);

  // count frames, free the slot after the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt        <= FRAME_REF;
    end else if (advance) begin
      hold_valid <= in.valid;
      cnt        <= FRAME_REF;
    end else if (m_tready) begin
      cnt <= cnt + 2'd1;
    end
  end

  // x = quotient / 2, word = (x / 64) << 7 | x % 64
  always_ff @(posedge clk) begin
    if (advance) begin
      hold_bad  <= in.bad;
      hold_word <= {in.num[19:7], 1'b0, in.num[6:1]};
    end
  end

  // frame contents
  always_comb begin
    case (cnt)
      FRAME_REF: begin
        addr  = ADDR_REF;
        value = ref_divider;
      end
      FRAME_ZERO: begin
        addr  = ADDR_ZERO;
        value = '0;
      end
      default: begin
        addr  = ADDR_WORD;
        value = hold_word;
      end
    endcase
    frame = hold_bad ? '0 : {value, 1'b1, addr};
  end

  assign m_tvalid = hold_valid;
  assign m_tdata  = {7'd0, frame};
  assign m_tlast  = last;
  assign m_tuser  = hold_bad;

endmodule
